// ----- hw/rtl/logistic_coordinate_update_top_macros.svh -----
// assertion macros shared by the logistic coordinate update rtl
`ifndef LOGISTIC_COORDINATE_UPDATE_TOP_MACROS_SVH
`define LOGISTIC_COORDINATE_UPDATE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define LCU_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");
`define LCU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LCU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LCU_ASSERT(lbl, cond)
`define LCU_ASSERT_IMP(lbl, ante, cons)
`define LCU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/lcu_pkg.sv -----
package lcu_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0]         idx;
        logic signed [23:0] x;
        logic               pos;
        logic               last;
        logic               clr;
    } t_item;

    typedef struct packed {
        logic [31:0] step_size;
        logic [23:0] reg_strength;
    } t_cfg;

endpackage

// ----- hw/rtl/lcu_fifo.sv -----
`include "logistic_coordinate_update_top_macros.svh"

module lcu_fifo
    import lcu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = r_count != QCNT_W'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10: begin
                    r_count <= r_count + 1'b1;
                end
                2'b01: begin
                    r_count <= r_count - 1'b1;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    `LCU_ASSERT(a_fifo_bound, r_count <= QCNT_W'(QDEPTH))

endmodule

// ----- hw/rtl/lcu_front.sv -----
module lcu_front
    import lcu_pkg::*;
#(
    parameter int FEATURES = 256
) (
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_feature_index,
    input  logic signed [23:0] i_sample_value,
    input  logic               i_label,
    input  logic               i_last_sample,
    input  logic               i_clear_weights,
    input  logic               i_q_ready,
    output logic               o_push,
    output t_item              o_item
);

    logic [19:0] rem_idx;

    // index reduction modulo the feature count, one conditional subtract per bit
    always_comb begin
        rem_idx = 20'(i_feature_index);
        for (int k = 7; k >= 0; k--) begin
            if (rem_idx >= (20'(FEATURES) << k)) begin
                rem_idx = rem_idx - (20'(FEATURES) << k);
            end
        end
    end

    assign o_in_ready  = i_q_ready;
    assign o_push      = i_in_valid && i_q_ready;
    assign o_item.idx  = rem_idx[7:0];
    assign o_item.x    = i_sample_value;
    assign o_item.pos  = i_label;
    assign o_item.last = i_last_sample;
    assign o_item.clr  = i_clear_weights;

endmodule

// ----- hw/rtl/lcu_back.sv -----
`include "logistic_coordinate_update_top_macros.svh"

module lcu_back
    import lcu_pkg::*;
#(
    parameter int FEATURES        = 256,
    parameter int SIGMOID_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  t_item              i_q_item,
    output logic               o_pop,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [7:0]         o_updated_index,
    output logic signed [31:0] o_new_weight
);

    localparam int ADDR_W = $clog2(FEATURES);
    localparam int SI_W   = $clog2(SIGMOID_ENTRIES);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_MW   = 4'd3;
    localparam logic [3:0] S_T    = 4'd4;
    localparam logic [3:0] S_MU   = 4'd5;
    localparam logic [3:0] S_TAB  = 4'd6;
    localparam logic [3:0] S_MS   = 4'd7;
    localparam logic [3:0] S_ACC  = 4'd8;
    localparam logic [3:0] S_ML   = 4'd9;
    localparam logic [3:0] S_DIFF = 4'd10;
    localparam logic [3:0] S_MH   = 4'd11;
    localparam logic [3:0] S_MLO  = 4'd12;
    localparam logic [3:0] S_WB   = 4'd13;

    localparam logic signed [56:0] P_LIM = 57'sd34359738368;

    localparam logic [15:0] SIG_POS [17] = '{
        16'd32768, 16'd40794, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
        16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
        16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
    };

    typedef logic [15:0] t_sig_tab [SIGMOID_ENTRIES];

    function automatic logic [15:0] f_knot(input int j);
        if (j >= 16) begin
            return SIG_POS[j - 16];
        end
        return 16'(32'd65536 - 32'(SIG_POS[16 - j]));
    endfunction

    // sigmoid over [-8, 8), interpolated between knots at steps of one half
    function automatic t_sig_tab f_sig_tab();
        t_sig_tab        tab;
        longint unsigned pos;
        longint unsigned frac;
        longint unsigned ka;
        longint unsigned kb;
        int              j;
        for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
            pos     = 64'((longint'(k) << 20) / SIGMOID_ENTRIES);
            j       = int'(pos >> 15);
            frac    = pos & 64'd32767;
            ka      = 64'(f_knot(j));
            kb      = 64'(f_knot(j + 1));
            tab[k]  = 16'(ka + (((kb - ka) * frac) >> 15));
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TAB = f_sig_tab();

    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic               r_has;
    logic [ADDR_W-1:0]  r_clr_addr;
    t_item              r_item;
    logic [31:0]        r_wmem [FEATURES];
    logic signed [31:0] r_rdata;
    logic signed [31:0] r_w;
    logic signed [65:0] r_prod;
    logic [20:0]        r_u;
    logic [15:0]        r_s;
    logic signed [47:0] r_gsum;
    logic [47:0]        r_mag;
    logic               r_neg;
    logic [55:0]        r_pa;
    logic               r_out_valid;
    logic [7:0]         r_out_idx;
    logic signed [31:0] r_out_w;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [31:0]        mem_wdata;
    logic               mem_we;
    logic               clr_last;
    logic               out_free;
    logic               wb_fire;
    logic signed [56:0] p_raw;
    logic signed [56:0] p_n;
    logic [20:0]        u_val;
    logic [12:0]        si_full;
    logic [SI_W-1:0]    si;
    logic signed [24:0] sx;
    logic signed [25:0] term;
    logic signed [48:0] gsum_add;
    logic signed [47:0] gsum_sat;
    logic signed [44:0] lw;
    logic signed [48:0] diff;
    logic [80:0]        dsum;
    logic [48:0]        delta;
    logic signed [50:0] sdelta;
    logic signed [51:0] nw_sum;
    logic signed [31:0] nw_sat;

    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign out_free = !r_out_valid || i_out_ready;
    assign wb_fire  = (r_state == S_WB) && out_free;
    assign clr_last = r_clr_addr == ADDR_W'(FEATURES - 1);

    assign rd_addr   = (r_state == S_IDLE) ? ADDR_W'(i_q_item.idx) : ADDR_W'(r_item.idx);
    assign mem_we    = (r_state == S_CLR) || wb_fire;
    assign mem_waddr = (r_state == S_CLR) ? r_clr_addr : ADDR_W'(r_item.idx);
    assign mem_wdata = (r_state == S_CLR) ? 32'd0 : nw_sat;

    // sigmoid argument, clamped to +-8 and offset into the table range
    assign p_raw = signed'(r_prod[56:0]);
    assign p_n   = r_item.pos ? -p_raw : p_raw;
    always_comb begin
        if (p_n > P_LIM) begin
            u_val = 21'h100000;
        end else if (p_n < -P_LIM) begin
            u_val = 21'd0;
        end else begin
            u_val = p_n[36:16] + 21'h080000;
        end
    end

    assign si_full = r_prod[32:20];
    assign si      = (si_full >= 13'(SIGMOID_ENTRIES)) ? SI_W'(SIGMOID_ENTRIES - 1)
                                                      : si_full[SI_W-1:0];

    assign sx = r_item.pos ? 25'(r_item.x) : -25'(r_item.x);

    assign term     = signed'(r_prod[41:16]);
    assign gsum_add = 49'(r_gsum) + 49'(term);
    always_comb begin
        if (gsum_add[48] != gsum_add[47]) begin
            gsum_sat = gsum_add[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            gsum_sat = gsum_add[47:0];
        end
    end

    assign lw   = signed'(r_prod[56:12]);
    assign diff = 49'(r_gsum) - 49'(lw);

    // delta = (mag * eta) >> 32 from two partial products
    assign dsum   = 81'({r_pa, 24'd0}) + 81'(r_prod[55:0]);
    assign delta  = dsum[80:32];
    assign sdelta = r_neg ? -51'(delta) : 51'(delta);
    assign nw_sum = 52'(r_w) + 52'(sdelta);
    always_comb begin
        if (nw_sum > 52'sh7FFFFFFF) begin
            nw_sat = 32'sh7FFFFFFF;
        end else if (nw_sum < -52'sh80000000) begin
            nw_sat = 32'sh80000000;
        end else begin
            nw_sat = nw_sum[31:0];
        end
    end

    // shared multiplier operands
    always_comb begin
        unique case (r_state)
            S_MW: begin
                mul_a = 33'(r_rdata);
                mul_b = 33'(r_item.x);
            end
            S_MU: begin
                mul_a = 33'(r_u);
                mul_b = 33'(SIGMOID_ENTRIES);
            end
            S_MS: begin
                mul_a = 33'(sx);
                mul_b = 33'(r_s);
            end
            S_ML: begin
                mul_a = 33'(r_w);
                mul_b = 33'(i_cfg.reg_strength);
            end
            S_MH: begin
                mul_a = 33'(r_mag[47:24]);
                mul_b = 33'(i_cfg.step_size);
            end
            S_MLO, S_WB: begin
                mul_a = 33'(r_mag[23:0]);
                mul_b = 33'(i_cfg.step_size);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (clr_last) begin
                    n_state = r_has ? S_RD : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_q_item.clr ? S_CLR : S_MW;
                end
            end
            S_RD:   n_state = S_MW;
            S_MW:   n_state = S_T;
            S_T:    n_state = S_MU;
            S_MU:   n_state = S_TAB;
            S_TAB:  n_state = S_MS;
            S_MS:   n_state = S_ACC;
            S_ACC:  n_state = r_item.last ? S_ML : S_IDLE;
            S_ML:   n_state = S_DIFF;
            S_DIFF: n_state = S_MH;
            S_MH:   n_state = S_MLO;
            S_MLO:  n_state = S_WB;
            S_WB: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_wmem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_wmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_has       <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_gsum      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + 1'b1;
            end
            if (o_pop) begin
                r_has <= 1'b1;
            end else if (((r_state == S_ACC) && !r_item.last) || wb_fire) begin
                r_has <= 1'b0;
            end
            if (r_state == S_ACC) begin
                r_gsum <= gsum_sat;
            end else if (wb_fire) begin
                r_gsum <= '0;
            end
            if (wb_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 66'(mul_a) * 66'(mul_b);
        if (o_pop) begin
            r_item <= i_q_item;
        end
        if (r_state == S_MW) begin
            r_w <= r_rdata;
        end
        if (r_state == S_T) begin
            r_u <= u_val;
        end
        if (r_state == S_TAB) begin
            r_s <= SIG_TAB[si];
        end
        if (r_state == S_DIFF) begin
            r_neg <= diff < 0;
            r_mag <= (diff < 0) ? 48'(-diff) : 48'(diff);
        end
        if (r_state == S_MLO) begin
            r_pa <= r_prod[55:0];
        end
        if (wb_fire) begin
            r_out_idx <= r_item.idx;
            r_out_w   <= nw_sat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_updated_index = r_out_idx;
    assign o_new_weight    = r_out_w;

    `LCU_ASSERT_IMP(a_wb_last, r_state == S_WB, r_item.last)
    `LCU_ASSERT_NXT(a_out_hold, r_out_valid && !i_out_ready, r_out_valid && $stable(r_out_w))
    `LCU_ASSERT_IMP(a_item_held, (r_state != S_IDLE) && (r_state != S_CLR), r_has)

endmodule

// ----- hw/rtl/logistic_coordinate_update_top.sv -----
// Coordinate update for L2-regularized logistic regression in fixed point. Each input word
// carries one sample of a feature column; the front takes a word in any cycle while its
// two-word queue has room, and the back works one word at a time through a sequencer that
// shares a single 33x33 multiplier and a weight memory with one read and one write port. A
// word not marked last goes through the multiply, table and accumulate states; a last word
// also passes the regularization, step and write-back states, waits there until the output
// register is empty, and produces one result word with the new saturated weight. A word
// with clear_weights set first zeroes the weight memory, which the back also does after
// reset, before it pops its first word. Configuration writes are taken in any cycle.
module logistic_coordinate_update_top
    import lcu_pkg::*;
#(
    parameter int FEATURES        = 256,
    parameter int SIGMOID_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_feature_index,
    input  logic signed [23:0] i_sample_value,
    input  logic               i_label,
    input  logic               i_last_sample,
    input  logic               i_clear_weights,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_updated_index,
    output logic signed [31:0] o_new_weight,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam logic [0:0]  CFG_STEP_SIZE    = 1'b0;
    localparam logic [0:0]  CFG_REG_STRENGTH = 1'b1;
    localparam logic [31:0] STEP_SIZE_RST    = 32'd42950;

    t_cfg  r_cfg;
    t_item front_item;
    t_item q_item;
    logic  front_push;
    logic  q_ready;
    logic  q_valid;
    logic  q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size    <= STEP_SIZE_RST;
            r_cfg.reg_strength <= 24'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEP_SIZE: begin
                    r_cfg.step_size <= i_cfg_data;
                end
                CFG_REG_STRENGTH: begin
                    r_cfg.reg_strength <= i_cfg_data[23:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    lcu_front #(
        .FEATURES(FEATURES)
    ) u_front (
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_feature_index (i_feature_index),
        .i_sample_value  (i_sample_value),
        .i_label         (i_label),
        .i_last_sample   (i_last_sample),
        .i_clear_weights (i_clear_weights),
        .i_q_ready       (q_ready),
        .o_push          (front_push),
        .o_item          (front_item)
    );

    lcu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    lcu_back #(
        .FEATURES        (FEATURES),
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_pop           (q_pop),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_updated_index (o_updated_index),
        .o_new_weight    (o_new_weight)
    );

endmodule
